FILE: design/cet_pkg.sv
// ----------------------------------------------------------------------------
// cet_pkg
// shared widths, codes and item types of the conformation energy table
// ----------------------------------------------------------------------------
package cet_pkg;

    localparam int KIND_W      = 3;
    localparam int POS_W       = 4;
    localparam int CONF_W      = 4;
    localparam int COUNT_W     = 5;
    localparam int IN_ENERGY_W = 32;
    localparam int VALUE_W     = 40;
    localparam int STATUS_W    = 3;
    localparam int ELEM_W      = 5;
    localparam int NUMPOS_W    = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_SET_COUNT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE_SINGLE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE_PAIR   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STREAM       = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ_SINGLE  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_READ_PAIR    = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_POS    = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_CONF   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_EQUAL  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_LENGTH = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_POSITIONS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONST_TERM    = 1'b1;

    localparam logic [ELEM_W-1:0] ELEM_MAX = 5'd31;

    localparam logic signed [VALUE_W-1:0] TOTAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] TOTAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef struct packed {
        logic [KIND_W-1:0]             kind;
        logic [POS_W-1:0]              pos_a;
        logic [CONF_W-1:0]             conf_a;
        logic [POS_W-1:0]              pos_b;
        logic [CONF_W-1:0]             conf_b;
        logic [COUNT_W-1:0]            count;
        logic signed [IN_ENERGY_W-1:0] energy;
        logic                          last;
        logic                          same_pos;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_entry_t;

endpackage

FILE: design/cet_if.sv
// ----------------------------------------------------------------------------
// cet_if
// valid/ready channels for incoming items and results
// ----------------------------------------------------------------------------
interface cet_item_if import cet_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic [KIND_W-1:0]             kind;
    logic [POS_W-1:0]              pos_a;
    logic [CONF_W-1:0]             conf_a;
    logic [POS_W-1:0]              pos_b;
    logic [CONF_W-1:0]             conf_b;
    logic [COUNT_W-1:0]            count;
    logic signed [IN_ENERGY_W-1:0] energy;
    logic                          last;

    modport source (output valid, kind, pos_a, conf_a, pos_b, conf_b, count, energy, last,
                    input ready);
    modport sink   (input valid, kind, pos_a, conf_a, pos_b, conf_b, count, energy, last,
                    output ready);
endinterface

interface cet_result_if import cet_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

FILE: design/cet_front.sv
// ----------------------------------------------------------------------------
// cet_front
// accepts items, drops unused kinds, orders pair positions high first
// ----------------------------------------------------------------------------
module cet_front import cet_pkg::*; (
    cet_item_if.sink items,
    input  logic     q_full,
    input  logic     clearing,
    output q_entry_t push
);

    logic is_pair;
    logic swap;

    assign items.ready = !q_full && !clearing;

    always_comb
    begin
        is_pair = (items.kind == KIND_WRITE_PAIR) || (items.kind == KIND_READ_PAIR);
        swap    = is_pair && (items.pos_a < items.pos_b);

        push.valid = items.valid && items.ready && (items.kind inside {[KIND_SET_COUNT:KIND_READ_PAIR]});
        push.item.kind     = items.kind;
        push.item.pos_a    = swap ? items.pos_b : items.pos_a;
        push.item.conf_a   = swap ? items.conf_b : items.conf_a;
        push.item.pos_b    = swap ? items.pos_a : items.pos_b;
        push.item.conf_b   = swap ? items.conf_a : items.conf_b;
        push.item.count    = items.count;
        push.item.energy   = items.energy;
        push.item.last     = items.last;
        push.item.same_pos = (items.pos_a == items.pos_b);
    end

endmodule

FILE: design/cet_queue.sv
// ----------------------------------------------------------------------------
// cet_queue
// short fifo between the front and the back
// ----------------------------------------------------------------------------
module cet_queue import cet_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  q_entry_t push,
    input  logic     pop,
    output logic     full,
    output q_entry_t head
);

    item_t          slot_reg [QUEUE_DEPTH];
    logic [QPW-1:0] wr_ptr_reg;
    logic [QPW-1:0] rd_ptr_reg;
    logic [QCW-1:0] fill_reg;

    logic           do_push;
    logic           do_pop;

    assign full       = (int'(fill_reg) == QUEUE_DEPTH);
    assign head.valid = (fill_reg != '0);
    assign head.item  = slot_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                slot_reg[wr_ptr_reg] <= push.item;
                wr_ptr_reg <= (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
                rd_ptr_reg <= (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                fill_reg <= fill_reg + 1'b1;
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

FILE: design/cet_back.sv
// ----------------------------------------------------------------------------
// cet_back
// sequencer over the count, single, pair and chosen conformation stores
// ----------------------------------------------------------------------------
module cet_back import cet_pkg::*; #(
    parameter int MAX_POSITIONS = 16,
    parameter int MAX_CONFS     = 16,
    parameter int ENERGY_BITS   = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  q_entry_t               head,
    output logic                   pop,
    output logic                   clearing,
    cet_result_if.source           results
);

    localparam int PW         = $clog2(MAX_POSITIONS);
    localparam int CFW        = (MAX_CONFS > 1) ? $clog2(MAX_CONFS) : 1;
    localparam int CNW        = $clog2(MAX_CONFS + 1);
    localparam int NW         = $clog2(MAX_POSITIONS + 1);
    localparam int CW         = (NW > ELEM_W) ? NW : ELEM_W;
    localparam int SGL_DEPTH  = MAX_POSITIONS * MAX_CONFS;
    localparam int SA         = $clog2(SGL_DEPTH);
    localparam int PAIR_DEPTH = MAX_POSITIONS * (MAX_POSITIONS - 1) / 2 * MAX_CONFS * MAX_CONFS;
    localparam int PA         = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
    localparam int CLR_DEPTH  = (PAIR_DEPTH > SGL_DEPTH) ? PAIR_DEPTH : SGL_DEPTH;
    localparam int CLW        = $clog2(CLR_DEPTH);
    localparam int SUMW       = ((ENERGY_BITS > VALUE_W) ? ENERGY_BITS : VALUE_W) + 2;
    localparam int STEP       = MAX_CONFS * MAX_CONFS;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_CHK,
        ST_READ_SGL,
        ST_PAIR_A,
        ST_PAIR_B,
        ST_PAIR_ACC,
        ST_READ_PAIR,
        ST_STRM_CNT,
        ST_STRM_SGL,
        ST_STRM_CH,
        ST_STRM_PAIR,
        ST_STRM_FIN,
        ST_OUT
    } state_t;

    // storage
    logic [CNW-1:0]                count_mem  [MAX_POSITIONS];
    logic [ENERGY_BITS-1:0]        single_mem [SGL_DEPTH];
    logic [ENERGY_BITS-1:0]        pair_mem   [PAIR_DEPTH];
    logic [CFW-1:0]                chosen_mem [MAX_POSITIONS];

    logic [CNW-1:0]                count_rd_reg;
    logic signed [ENERGY_BITS-1:0] single_rd_reg;
    logic signed [ENERGY_BITS-1:0] pair_rd_reg;
    logic [CFW-1:0]                chosen_rd_reg;

    // sequencer state
    state_t                        state_reg, state_next;
    item_t                         item_reg, item_next;
    logic [CLW-1:0]                clr_reg, clr_next;
    logic [CNW-1:0]                cnt_a_reg, cnt_a_next;
    logic [PA-1:0]                 pbase_reg, pbase_next;
    logic [PW-1:0]                 p_reg, p_next;
    logic [ELEM_W-1:0]             elem_reg, elem_next;
    logic signed [VALUE_W-1:0]     total_reg, total_next;
    logic [STATUS_W-1:0]           perr_reg, perr_next;
    logic signed [VALUE_W-1:0]     value_reg, value_next;
    logic [STATUS_W-1:0]           status_reg, status_next;
    logic [NUMPOS_W-1:0]           num_pos_reg, num_pos_next;
    logic signed [CFG_DATA_W-1:0]  const_reg, const_next;

    // memory ports
    logic                          count_we;
    logic [PW-1:0]                 count_waddr, count_raddr;
    logic [CNW-1:0]                count_wdata;
    logic                          single_we;
    logic [SA-1:0]                 single_waddr, single_raddr;
    logic [ENERGY_BITS-1:0]        single_wdata;
    logic                          pair_we;
    logic [PA-1:0]                 pair_waddr, pair_raddr;
    logic [ENERGY_BITS-1:0]        pair_wdata;
    logic                          chosen_we;
    logic [PW-1:0]                 chosen_waddr, chosen_raddr;
    logic [CFW-1:0]                chosen_wdata;

    logic [NW-1:0]                 n_pos;
    logic [ELEM_W-1:0]             elem_inc;
    logic [STATUS_W-1:0]           fin_status;

    function automatic logic [SA-1:0] sgl_addr(input logic [CW-1:0] p,
                                               input logic [CONF_W-1:0] c);
        sgl_addr = SA'(int'(p) * MAX_CONFS + int'(c));
    endfunction

    function automatic logic [PA-1:0] pair_base(input logic [CW-1:0] p1,
                                                input logic [POS_W-1:0] p2,
                                                input logic [CONF_W-1:0] c1);
        int tri_n;
        tri_n = (int'(p1) * (int'(p1) - 1)) >>> 1;
        pair_base = PA'(((tri_n + int'(p2)) * MAX_CONFS + int'(c1)) * MAX_CONFS);
    endfunction

    function automatic logic signed [VALUE_W-1:0] sat_add(
        input logic signed [VALUE_W-1:0]     a,
        input logic signed [ENERGY_BITS-1:0] b);
        logic signed [SUMW-1:0] s;
        s = SUMW'(a) + SUMW'(b);
        if (s > SUMW'(TOTAL_MAX))
            sat_add = TOTAL_MAX;
        else if (s < SUMW'(TOTAL_MIN))
            sat_add = TOTAL_MIN;
        else
            sat_add = VALUE_W'(s);
    endfunction

    function automatic logic in_range(input logic [POS_W-1:0] p, input logic [NW-1:0] n);
        in_range = CW'(p) < CW'(n);
    endfunction

    assign n_pos    = (int'(num_pos_reg) > MAX_POSITIONS) ? NW'(MAX_POSITIONS) : NW'(num_pos_reg);
    assign elem_inc = (elem_reg == ELEM_MAX) ? elem_reg : elem_reg + 1'b1;

    assign clearing       = (state_reg == ST_CLEAR);
    assign results.valid  = (state_reg == ST_OUT);
    assign results.value  = value_reg;
    assign results.status = status_reg;

    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        clr_next     = clr_reg;
        cnt_a_next   = cnt_a_reg;
        pbase_next   = pbase_reg;
        p_next       = p_reg;
        elem_next    = elem_reg;
        total_next   = total_reg;
        perr_next    = perr_reg;
        value_next   = value_reg;
        status_next  = status_reg;
        num_pos_next = num_pos_reg;
        const_next   = const_reg;
        fin_status   = perr_reg;

        pop          = 1'b0;
        count_we     = 1'b0;
        count_waddr  = PW'(item_reg.pos_a);
        count_wdata  = CNW'(item_reg.count);
        count_raddr  = PW'(item_reg.pos_a);
        single_we    = 1'b0;
        single_waddr = sgl_addr(CW'(item_reg.pos_a), item_reg.conf_a);
        single_wdata = ENERGY_BITS'(item_reg.energy);
        single_raddr = sgl_addr(CW'(item_reg.pos_a), item_reg.conf_a);
        pair_we      = 1'b0;
        pair_waddr   = pbase_reg + PA'(item_reg.conf_b);
        pair_wdata   = ENERGY_BITS'(item_reg.energy);
        pair_raddr   = pbase_reg + PA'(item_reg.conf_b);
        chosen_we    = 1'b0;
        chosen_waddr = PW'(elem_reg);
        chosen_wdata = CFW'(item_reg.conf_a);
        chosen_raddr = p_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_POSITIONS: num_pos_next = cfg_data[NUMPOS_W-1:0];
                CFG_CONST_TERM:    const_next   = $signed(cfg_data);
                default:           ;
            endcase
        end

        case (state_reg)
            ST_CLEAR:
            begin
                count_we     = int'(clr_reg) < MAX_POSITIONS;
                count_waddr  = clr_reg[PW-1:0];
                count_wdata  = '0;
                single_we    = int'(clr_reg) < SGL_DEPTH;
                single_waddr = clr_reg[SA-1:0];
                single_wdata = '0;
                pair_we      = int'(clr_reg) < PAIR_DEPTH;
                pair_waddr   = clr_reg[PA-1:0];
                pair_wdata   = '0;
                if (int'(clr_reg) == CLR_DEPTH - 1)
                    state_next = ST_IDLE;
                else
                    clr_next = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    item_next  = head.item;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                value_next = '0;
                case (item_reg.kind)
                    KIND_SET_COUNT:
                    begin
                        state_next = ST_OUT;
                        if (!in_range(item_reg.pos_a, n_pos))
                            status_next = STATUS_POS;
                        else if (int'(item_reg.count) > MAX_CONFS)
                            status_next = STATUS_CONF;
                        else
                        begin
                            count_we    = 1'b1;
                            status_next = STATUS_OK;
                        end
                    end
                    KIND_WRITE_SINGLE, KIND_READ_SINGLE:
                    begin
                        if (!in_range(item_reg.pos_a, n_pos))
                        begin
                            status_next = STATUS_POS;
                            state_next  = ST_OUT;
                        end
                        else
                            state_next = ST_CHK;
                    end
                    KIND_WRITE_PAIR, KIND_READ_PAIR:
                    begin
                        if (item_reg.same_pos)
                        begin
                            status_next = STATUS_EQUAL;
                            state_next  = ST_OUT;
                        end
                        else if (!in_range(item_reg.pos_a, n_pos) ||
                                 !in_range(item_reg.pos_b, n_pos))
                        begin
                            status_next = STATUS_POS;
                            state_next  = ST_OUT;
                        end
                        else
                            state_next = ST_PAIR_A;
                    end
                    KIND_STREAM:
                    begin
                        // the first element of a stream starts from the constant term
                        if (elem_reg == '0)
                            total_next = VALUE_W'(const_reg);
                        p_next      = '0;
                        count_raddr = PW'(elem_reg);
                        if (perr_reg != STATUS_OK)
                            state_next = ST_STRM_FIN;
                        else if (CW'(elem_reg) >= CW'(n_pos))
                        begin
                            perr_next  = STATUS_LENGTH;
                            state_next = ST_STRM_FIN;
                        end
                        else
                            state_next = ST_STRM_CNT;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_CHK:
            begin
                if (int'(item_reg.conf_a) >= int'(count_rd_reg))
                begin
                    status_next = STATUS_CONF;
                    state_next  = ST_OUT;
                end
                else if (item_reg.kind == KIND_WRITE_SINGLE)
                begin
                    single_we   = 1'b1;
                    status_next = STATUS_OK;
                    state_next  = ST_OUT;
                end
                else
                    state_next = ST_READ_SGL;
            end
            ST_READ_SGL:
            begin
                value_next  = VALUE_W'(single_rd_reg);
                status_next = STATUS_OK;
                state_next  = ST_OUT;
            end
            ST_PAIR_A:
            begin
                cnt_a_next  = count_rd_reg;
                count_raddr = PW'(item_reg.pos_b);
                state_next  = ST_PAIR_B;
            end
            ST_PAIR_B:
            begin
                if ((int'(item_reg.conf_a) >= int'(cnt_a_reg)) ||
                    (int'(item_reg.conf_b) >= int'(count_rd_reg)))
                begin
                    status_next = STATUS_CONF;
                    state_next  = ST_OUT;
                end
                else
                begin
                    pbase_next = pair_base(CW'(item_reg.pos_a), item_reg.pos_b, item_reg.conf_a);
                    state_next = ST_PAIR_ACC;
                end
            end
            ST_PAIR_ACC:
            begin
                status_next = STATUS_OK;
                if (item_reg.kind == KIND_WRITE_PAIR)
                begin
                    pair_we    = 1'b1;
                    state_next = ST_OUT;
                end
                else
                    state_next = ST_READ_PAIR;
            end
            ST_READ_PAIR:
            begin
                value_next = VALUE_W'(pair_rd_reg);
                state_next = ST_OUT;
            end
            ST_STRM_CNT:
            begin
                if (int'(item_reg.conf_a) >= int'(count_rd_reg))
                begin
                    perr_next  = STATUS_CONF;
                    state_next = ST_STRM_FIN;
                end
                else
                begin
                    chosen_we    = 1'b1;
                    single_raddr = sgl_addr(CW'(elem_reg), item_reg.conf_a);
                    pbase_next   = pair_base(CW'(elem_reg), '0, item_reg.conf_a);
                    state_next   = ST_STRM_SGL;
                end
            end
            ST_STRM_SGL:
            begin
                total_next = sat_add(total_reg, single_rd_reg);
                state_next = (elem_reg == '0) ? ST_STRM_FIN : ST_STRM_CH;
            end
            ST_STRM_CH:
            begin
                pair_raddr = pbase_reg + PA'(chosen_rd_reg);
                state_next = ST_STRM_PAIR;
            end
            ST_STRM_PAIR:
            begin
                total_next   = sat_add(total_reg, pair_rd_reg);
                pbase_next   = pbase_reg + PA'(STEP);
                p_next       = p_reg + 1'b1;
                chosen_raddr = p_reg + 1'b1;
                if (CW'(p_reg) + 1'b1 == CW'(elem_reg))
                    state_next = ST_STRM_FIN;
                else
                    state_next = ST_STRM_CH;
            end
            ST_STRM_FIN:
            begin
                if (!item_reg.last)
                begin
                    elem_next  = elem_inc;
                    state_next = ST_IDLE;
                end
                else
                begin
                    if ((fin_status == STATUS_OK) && (CW'(elem_inc) != CW'(n_pos)))
                        fin_status = STATUS_LENGTH;
                    status_next = fin_status;
                    value_next  = (fin_status == STATUS_OK) ? total_reg : '0;
                    elem_next   = '0;
                    total_next  = '0;
                    perr_next   = STATUS_OK;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (results.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            item_reg    <= '0;
            clr_reg     <= '0;
            cnt_a_reg   <= '0;
            pbase_reg   <= '0;
            p_reg       <= '0;
            elem_reg    <= '0;
            total_reg   <= '0;
            perr_reg    <= STATUS_OK;
            value_reg   <= '0;
            status_reg  <= STATUS_OK;
            num_pos_reg <= NUMPOS_W'(1);
            const_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            item_reg    <= item_next;
            clr_reg     <= clr_next;
            cnt_a_reg   <= cnt_a_next;
            pbase_reg   <= pbase_next;
            p_reg       <= p_next;
            elem_reg    <= elem_next;
            total_reg   <= total_next;
            perr_reg    <= perr_next;
            value_reg   <= value_next;
            status_reg  <= status_next;
            num_pos_reg <= num_pos_next;
            const_reg   <= const_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (count_we)
            count_mem[count_waddr] <= count_wdata;
        count_rd_reg <= count_mem[count_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (single_we)
            single_mem[single_waddr] <= single_wdata;
        single_rd_reg <= single_mem[single_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pair_we)
            pair_mem[pair_waddr] <= pair_wdata;
        pair_rd_reg <= pair_mem[pair_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (chosen_we)
            chosen_mem[chosen_waddr] <= chosen_wdata;
        chosen_rd_reg <= chosen_mem[chosen_raddr];
    end

endmodule

FILE: design/conformation_energy_table.sv
// ----------------------------------------------------------------------------
// conformation_energy_table
// count, single and pair energy stores with conformation stream totals
// ----------------------------------------------------------------------------
// items arrive on the valid/ready channel "items"; results leave on "results"
// the front takes an item whenever the two-entry queue has room, so items keep
// flowing in while the back works or a result waits to be taken
// kinds 6 and 7 are taken and dropped; stream elements without last give nothing
// back steps per item, from the queue to the result:
//   set count: range checks, then the count write; single write or read: a
//   count read, then the single store; pair: two count reads, then the pair
//   store; stream element at position e: a count read, a single read, then
//   one pair store read per earlier position (chosen conformation read, then
//   pair read)
// a result sits in the output register until results.ready; the back holds
// the next item in the queue while the receiver stalls
// after reset the back sweeps the count, single and pair stores to zero,
// one entry a cycle, and items.ready stays low until it finishes;
// configuration writes are taken
// throughout
// ----------------------------------------------------------------------------
module conformation_energy_table import cet_pkg::*; #(
    parameter int MAX_POSITIONS = 16,
    parameter int MAX_CONFS     = 16,
    parameter int ENERGY_BITS   = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    cet_item_if.sink               items,
    cet_result_if.source           results
);

    // front to queue
    q_entry_t push;
    logic     q_full;

    // queue to back
    q_entry_t head;
    logic     pop;

    // back holds the front off during the clearing sweep
    logic     clearing;

    cet_front u_front (
        .items    (items),
        .q_full   (q_full),
        .clearing (clearing),
        .push     (push)
    );

    cet_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    cet_back #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .MAX_CONFS     (MAX_CONFS),
        .ENERGY_BITS   (ENERGY_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (head),
        .pop       (pop),
        .clearing  (clearing),
        .results   (results)
    );

endmodule
